// ----- rtl/core/bdq_pkg.sv -----
// Shared types and constants for the bounded deque block.
// Used by bdq_ring_ram, bdq_ctrl and bounded_deque_unit; depends on nothing.
package bdq_pkg;

   localparam int WORD_W        = 32;
   localparam int OCC_W         = 5;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_REAR  = 2'd1,
      OP_REM_FRONT = 2'd2,
      OP_REM_REAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_RESP = 2'd2
   } state_type;

   typedef struct packed {
      op_type                     opcode;
      logic signed [WORD_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [WORD_W-1:0]   removed_value;
      logic [OCC_W-1:0]           occupancy;
   } rsp_type;

endpackage

// ----- rtl/core/bdq_ring_ram.sv -----
// Slot store of the deque ring: one write port, one read port, registered read data.
// Depends on bdq_pkg for the word width.
module bdq_ring_ram
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [WORD_W-1:0]        rd_data_ff
);

   logic [WORD_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/core/bdq_ctrl.sv -----
// Head pointer, word count and handshake sequencer of the deque.
// Drives the slot store ports; depends on bdq_pkg.
module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_payload,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic [WORD_W-1:0]   wr_data,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  logic [WORD_W-1:0]   rd_data
);

   localparam int SW = AW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_accept;
   logic              is_ins, full, empty, ins_ok, rem_ok;
   logic [AW-1:0]     head_inc, head_dec, tail_addr, last_addr;
   logic [SW-1:0]     tail_sum, last_sum;

   assign req_accept = req_valid && req_ready;
   assign is_ins     = (req_payload.opcode == OP_INS_FRONT) ||
                       (req_payload.opcode == OP_INS_REAR);
   assign full       = (count_ff == DEPTH_C);
   assign empty      = (count_ff == '0);
   assign ins_ok     = is_ins && !full;
   assign rem_ok     = !is_ins && !empty;

   // Ring arithmetic: every sum stays below twice the depth, so one subtract wraps it
   assign head_inc  = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
   assign head_dec  = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign last_sum  = tail_sum - SW'(1);
   assign tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
   assign last_addr = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = rem_ok ? S_READ : S_RESP;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (req_accept) begin
               state_in = rem_ok ? S_READ : S_RESP;
            end else if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Handshake outputs: take a new word in the cycle the pending result leaves
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_READ:  req_ready = 1'b0;
         S_RESP: begin
            req_ready = rsp_ready;
            rsp_valid = 1'b1;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // Pointer, count, store access and result word
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_addr;
      wr_data  = req_payload.value;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      if (state_ff == S_READ) begin
         rsp_in.removed_value = rd_data;
      end
      if (req_accept) begin
         rsp_in.status        = ST_OK;
         rsp_in.removed_value = '0;
         if (is_ins && full) begin
            rsp_in.status = ST_FULL;
         end else if (!is_ins && empty) begin
            rsp_in.status = ST_EMPTY;
         end
         unique case (req_payload.opcode)
            OP_INS_FRONT: begin
               if (ins_ok) begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_INS_REAR: begin
               if (ins_ok) begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_addr;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_REM_FRONT: begin
               if (rem_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  head_in  = head_inc;
                  count_in = count_ff - CW'(1);
               end
            end
            OP_REM_REAR: begin
               if (rem_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = last_addr;
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               head_in = head_ff;
            end
         endcase
         rsp_in.occupancy = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   a_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_RESP)
      else $error("store read not followed by result");

   a_one_port_use: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read in one cycle");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      req_accept && ins_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted insert did not raise the count");

   a_empty_reject: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_ins && empty |=>
         state_ff == S_RESP && rsp_ff.status == ST_EMPTY && count_ff == '0)
      else $error("removal from empty store not rejected");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_ins && full |=> count_ff == DEPTH_C && rsp_ff.status == ST_FULL)
      else $error("insert into full store not rejected");

endmodule

// ----- rtl/core/bounded_deque_unit.sv -----
// Bounded double-ended queue of signed words: top level.
// Joins the sequencer bdq_ctrl to the slot store bdq_ring_ram; depends on bdq_pkg.
//
// Use: each word on the req_ channel is one operation (insert front, insert
// rear, remove front, remove rear) with its value. The rsp_ channel returns one
// word per operation: status (ok, full, empty), the removed value on a good
// removal and the occupancy afterwards. Both channels are valid/ready.
// An insert or a rejected operation gives its result in the cycle after
// acceptance; a removal passes through S_READ, the registered read of the slot
// store, and then S_RESP. A new word is taken in the cycle the pending result is
// taken, so while the receiver does not stall, throughput is one operation per
// cycle for inserts and rejects; no new word is taken while a removal is in S_READ.
// Reset (synchronous) empties the deque by clearing head and count; slot
// contents are not cleared. While the receiver stalls, the result holds and no
// new operation is taken.
module bounded_deque_unit
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_payload,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   bdq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   bdq_ring_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

endmodule

// ----- sim/tb_bounded_deque_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bounded_deque_unit: directed and biased random operations
// are checked against a ring-buffer deque predictor. Depends on bdq_pkg and the RTL.
module tb_bounded_deque_unit
   import bdq_pkg::*;
();

   localparam int DEPTH      = DEPTH_DEFAULT;
   localparam int RAND_OPS   = 1350;
   localparam int QUIET_TAIL = 200;

   typedef struct {
      req_type word;
      bit      drain_first;
   } op_entry_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   op_entry_type      pending_ops[$];
   rsp_type           expected_rsps[$];
   logic [WORD_W-1:0] ring_img [DEPTH];
   int                front_idx;
   int                fill_count;
   int                errors;
   bit                req_taken;
   int                send_gap;
   int                recv_stall;
   op_entry_type      next_op;
   rsp_type           want;

   bounded_deque_unit #(.DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the deque image and return its result word.
   function automatic rsp_type deque_apply(req_type w);
      rsp_type r;
      int      pos;
      r.status        = ST_OK;
      r.removed_value = '0;
      if (w.opcode == OP_INS_FRONT || w.opcode == OP_INS_REAR) begin
         if (fill_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            if (w.opcode == OP_INS_FRONT) begin
               front_idx = (front_idx + DEPTH - 1) % DEPTH;
               pos       = front_idx;
            end else begin
               pos = (front_idx + fill_count) % DEPTH;
            end
            ring_img[pos] = w.value;
            fill_count++;
         end
      end else if (fill_count == 0) begin
         r.status = ST_EMPTY;
      end else if (w.opcode == OP_REM_FRONT) begin
         r.removed_value = ring_img[front_idx];
         front_idx       = (front_idx + 1) % DEPTH;
         fill_count--;
      end else begin
         r.removed_value = ring_img[(front_idx + fill_count - 1) % DEPTH];
         fill_count--;
      end
      r.occupancy = fill_count[OCC_W-1:0];
      return r;
   endfunction

   // Extremes now and then, otherwise a plain random word.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Idling rate follows the amount of stimulus left; none in the tail.
   function automatic bit take_break(int left);
      int rate_sel;
      rate_sel = (left / 150) % 3;
      if (left < QUIET_TAIL || rate_sel == 0)
         return 1'b0;
      return $urandom_range(0, (rate_sel == 1) ? 3 : 11) == 0;
   endfunction

   task automatic add_op(op_type op, logic [WORD_W-1:0] v, bit drain);
      op_entry_type e;
      e.word.opcode = op;
      e.word.value  = v;
      e.drain_first = drain;
      pending_ops.push_back(e);
   endtask

   task automatic build_stimulus();
      int bias_pct [7] = '{50, 85, 15, 70, 30, 95, 5};
      int bias;
      // removals from an empty deque
      add_op(OP_REM_FRONT, pick_word(), 1'b0);
      add_op(OP_REM_REAR, '1, 1'b0);
      // fill from both ends, extremes first
      add_op(OP_INS_FRONT, 32'h8000_0000, 1'b0);
      add_op(OP_INS_REAR, 32'h7fff_ffff, 1'b0);
      add_op(OP_INS_FRONT, 32'h0000_0000, 1'b0);
      add_op(OP_INS_REAR, 32'hffff_ffff, 1'b0);
      add_op(OP_INS_FRONT, 32'h5555_5555, 1'b0);
      add_op(OP_INS_REAR, 32'haaaa_aaaa, 1'b0);
      for (int i = 0; i < DEPTH - 6; i++)
         add_op((i % 2) ? OP_INS_REAR : OP_INS_FRONT, pick_word(), 1'b0);
      // inserts into a full deque
      add_op(OP_INS_FRONT, 32'h1234_5678, 1'b0);
      add_op(OP_INS_REAR, 32'h8765_4321, 1'b0);
      add_op(OP_REM_REAR, pick_word(), 1'b0);
      add_op(OP_REM_FRONT, pick_word(), 1'b0);
      // random walk; the insert bias swings so that both full and empty are hit often
      for (int i = 0; i < RAND_OPS; i++) begin
         bias = bias_pct[(i / 60) % 7];
         if ($urandom_range(1, 100) <= bias)
            add_op($urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT, pick_word(), i % 300 == 0);
         else
            add_op($urandom_range(0, 1) ? OP_REM_REAR : OP_REM_FRONT, pick_word(), i % 300 == 0);
      end
   endtask

   // Sender: hold the word until taken, then idle or present the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() == 0 ||
                      (pending_ops[0].drain_first && expected_rsps.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (take_break(pending_ops.size())) begin
            send_gap = $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else begin
            next_op = pending_ops.pop_front();
            req_payload <= next_op.word;
            req_valid   <= 1'b1;
         end
      end
   end

   // Receiver: stall in bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (take_break(pending_ops.size())) begin
         recv_stall = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check results before queueing the prediction for this edge's accepted word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: result with none expected: status %0d value %0d occ %0d",
                        $time, rsp_payload.status, rsp_payload.removed_value,
                        rsp_payload.occupancy);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload !== want) begin
                  errors++;
                  $display({"%0t: mismatch: expected status %0d value %0d occ %0d,",
                            " got status %0d value %0d occ %0d"},
                           $time, want.status, want.removed_value, want.occupancy,
                           rsp_payload.status, rsp_payload.removed_value,
                           rsp_payload.occupancy);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(deque_apply(req_payload));
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      errors      = 0;
      front_idx   = 0;
      fill_count  = 0;
      req_taken   = 1'b0;
      send_gap    = 0;
      recv_stall  = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      rsp_ready   = 1'b0;
      req_payload = '0;
      build_stimulus();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d words pending, %0d results outstanding",
               pending_ops.size(), expected_rsps.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
